### hw/rtl/mhs_pkg.sv
// Shared types, character codes and helpers for the mail header splitter.
`default_nettype none

package mhs_pkg;

    localparam int CNT_W = 16;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SP     = 8'd32;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] NAME_LO   = 8'd33;
    localparam logic [7:0] NAME_HI   = 8'd126;
    localparam logic [7:0] UPPER_LO  = 8'd65;
    localparam logic [7:0] UPPER_HI  = 8'd90;
    localparam logic [7:0] CASE_STEP = 8'd32;
    localparam int         HASH_SHIFT = 5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_INHDR,
        PH_LINESTART,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        SH_EMPTY,
        SH_CRONLY,
        SH_OTHER
    } shape_t;

    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_END    = 1'b1
    } kind_t;

    // Running state of the header being collected.
    typedef struct packed {
        logic [CNT_W-1:0] header_start;
        logic             colon_seen;
        logic [CNT_W-1:0] name_count;
        logic [CNT_W-1:0] value_count;
        logic [CNT_W-1:0] unfold_count;
        logic             bad_seen;
        logic [31:0]      hash;
        logic             prior_was_cr;
    } hdr_t;

    // One record; hash holds the raw name hash before reduction, the bucket after it.
    typedef struct packed {
        kind_t            record_kind;
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] total_length;
        logic [CNT_W-1:0] name_length;
        logic [CNT_W-1:0] value_length;
        logic [CNT_W-1:0] unfolded_length;
        logic             no_colon;
        logic             bad_name_chars;
        logic [31:0]      hash;
        logic             body_present;
        logic             last;
    } rec_t;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mhs_parser.sv
// Byte parser: header state, phase tracking and raw record generation.
`default_nettype none

module mhs_parser #(
    parameter int MAX_MESSAGE_BYTES = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 final_byte,
    output logic [1:0]                lane_valid,
    output mhs_pkg::rec_t             lane_rec [2],
    output logic [1:0]                rec_count
);
    import mhs_pkg::*;

    localparam int POS_LIMIT = (MAX_MESSAGE_BYTES - 1 < 65535) ? MAX_MESSAGE_BYTES - 1 : 65535;
    localparam logic [CNT_W-1:0] POS_MAX = CNT_W'(POS_LIMIT);

    logic [CNT_W-1:0] position_reg, position_next;
    phase_t           phase_reg, phase_next, phase_step;
    shape_t           shape_reg, shape_next, shape_step;
    hdr_t             hdr_reg, hdr_next, hdr_step, hdr_fresh;
    logic [1:0]       lane_valid_reg, lane_valid_next;
    rec_t             lane_rec_reg [2];
    rec_t             lane_rec_next [2];

    logic [CNT_W-1:0] pos_here, pos_after;
    logic             is_lf, is_cr, is_blank;
    logic             do_begin, do_take, emit_pre, emit_mid_end, emit_fin_end, emit_fin_hdr;
    logic             have_a, have_b;
    rec_t             rec_a, rec_b;

    function automatic hdr_t take_byte(input hdr_t h, input logic [7:0] b);
        hdr_t       r;
        logic [7:0] low;
        r   = h;
        low = (b inside {[UPPER_LO:UPPER_HI]}) ? b + CASE_STEP : b;
        if (!h.colon_seen) begin
            if (b == CH_COLON) begin
                r.colon_seen   = 1'b1;
                r.prior_was_cr = 1'b0;
            end
            else begin
                r.name_count = cnt_inc(h.name_count);
                if (!(b inside {[NAME_LO:NAME_HI]})) begin
                    r.bad_seen = 1'b1;
                end
                r.hash = (h.hash << HASH_SHIFT) - h.hash + 32'(low);
            end
        end
        else begin
            r.value_count = cnt_inc(h.value_count);
            if (b == CH_LF) begin
                r.prior_was_cr = 1'b0;
            end
            else if (b == CH_CR) begin
                if (h.prior_was_cr) begin
                    r.unfold_count = cnt_inc(h.unfold_count);
                end
                r.prior_was_cr = 1'b1;
            end
            else begin
                // A CR not followed by LF counts as a value byte after all.
                r.unfold_count = h.prior_was_cr ? cnt_inc(cnt_inc(h.unfold_count))
                                                : cnt_inc(h.unfold_count);
                r.prior_was_cr = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic rec_t header_rec(input hdr_t h, input logic [CNT_W-1:0] end_at);
        rec_t r;
        r              = '0;
        r.record_kind  = KIND_HEADER;
        r.offset       = h.header_start;
        r.total_length = end_at - h.header_start;
        if (h.colon_seen) begin
            r.name_length     = h.name_count;
            r.value_length    = h.value_count;
            r.unfolded_length = h.prior_was_cr ? cnt_inc(h.unfold_count) : h.unfold_count;
            r.bad_name_chars  = h.bad_seen;
            r.hash            = h.hash;
        end
        else begin
            r.no_colon = 1'b1;
        end
        return r;
    endfunction

    function automatic rec_t end_rec(input logic [CNT_W-1:0] body_at, input logic present);
        rec_t r;
        r              = '0;
        r.record_kind  = KIND_END;
        r.offset       = body_at;
        r.body_present = present;
        return r;
    endfunction

    assign is_lf     = (data_byte == CH_LF);
    assign is_cr     = (data_byte == CH_CR);
    assign is_blank  = (data_byte inside {CH_SP, CH_TAB});
    assign pos_here  = position_reg;
    assign pos_after = (position_reg < POS_MAX) ? position_reg + 1'b1 : POS_MAX;

    // Next phase and line shape, and which actions this byte triggers.
    always_comb
    begin
        phase_step   = phase_reg;
        shape_step   = shape_reg;
        do_begin     = 1'b0;
        do_take      = 1'b0;
        emit_pre     = 1'b0;
        emit_mid_end = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (is_lf) begin
                    emit_mid_end = 1'b1;
                    phase_step   = PH_DONE;
                end
                else begin
                    do_begin   = 1'b1;
                    phase_step = PH_INHDR;
                    shape_step = is_cr ? SH_CRONLY : SH_OTHER;
                end
            end
            PH_LINESTART:
            begin
                if (is_blank) begin
                    do_take    = 1'b1;
                    phase_step = PH_INHDR;
                    shape_step = SH_OTHER;
                end
                else if (is_lf) begin
                    emit_pre     = 1'b1;
                    emit_mid_end = 1'b1;
                    phase_step   = PH_DONE;
                end
                else begin
                    emit_pre   = 1'b1;
                    do_begin   = 1'b1;
                    phase_step = PH_INHDR;
                    shape_step = is_cr ? SH_CRONLY : SH_OTHER;
                end
            end
            PH_INHDR:
            begin
                if (shape_reg == SH_CRONLY && is_lf) begin
                    emit_mid_end = 1'b1;
                    phase_step   = PH_DONE;
                end
                else begin
                    do_take    = 1'b1;
                    shape_step = SH_OTHER;
                    if (is_lf) begin
                        phase_step = PH_LINESTART;
                    end
                end
            end
            default:
            begin
            end
        endcase

        emit_fin_end = final_byte && phase_step == PH_INHDR && shape_step == SH_CRONLY;
        emit_fin_hdr = final_byte && !emit_fin_end &&
                       (phase_step == PH_INHDR || phase_step == PH_LINESTART);

        if (final_byte) begin
            phase_next = PH_IDLE;
            shape_next = SH_EMPTY;
        end
        else begin
            phase_next = phase_step;
            shape_next = shape_step;
        end
    end

    // Header state update and the records this byte produces.
    always_comb
    begin
        hdr_fresh              = '0;
        hdr_fresh.header_start = pos_here;
        if (do_begin) begin
            hdr_step = take_byte(hdr_fresh, data_byte);
        end
        else if (do_take) begin
            hdr_step = take_byte(hdr_reg, data_byte);
        end
        else begin
            hdr_step = hdr_reg;
        end
        hdr_next      = final_byte ? hdr_t'('0) : hdr_step;
        position_next = final_byte ? '0 : pos_after;

        have_a = emit_pre;
        have_b = emit_mid_end || emit_fin_end || emit_fin_hdr;
        rec_a  = header_rec(hdr_reg, pos_here);
        if (emit_mid_end || emit_fin_end) begin
            rec_b = end_rec(pos_after, !final_byte);
        end
        else begin
            rec_b = header_rec(hdr_step, pos_after);
        end

        lane_rec_next[0]      = have_a ? rec_a : rec_b;
        lane_rec_next[0].last = !(have_a && have_b);
        lane_rec_next[1]      = rec_b;
        lane_rec_next[1].last = 1'b1;

        lane_valid_next[0] = take && (have_a || have_b);
        lane_valid_next[1] = take && have_a && have_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            position_reg   <= '0;
            phase_reg      <= PH_IDLE;
            shape_reg      <= SH_EMPTY;
            hdr_reg        <= '0;
            lane_valid_reg <= '0;
        end
        else begin
            lane_valid_reg <= lane_valid_next;
            if (take) begin
                position_reg <= position_next;
                phase_reg    <= phase_next;
                shape_reg    <= shape_next;
                hdr_reg      <= hdr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lane_rec_reg[0] <= lane_rec_next[0];
        lane_rec_reg[1] <= lane_rec_next[1];
    end

    assign lane_valid  = lane_valid_reg;
    assign lane_rec[0] = lane_rec_reg[0];
    assign lane_rec[1] = lane_rec_reg[1];
    assign rec_count   = {1'b0, lane_valid_next[0]} + {1'b0, lane_valid_next[1]};

endmodule

`default_nettype wire

### hw/rtl/mhs_bucket_pipe.sv
// Two-stage pipeline that reduces a record's 32-bit name hash to its bucket.
`default_nettype none

module mhs_bucket_pipe #(
    parameter int HASH_BUCKETS = 63
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire mhs_pkg::rec_t in_rec,
    output logic               out_valid,
    output mhs_pkg::rec_t      out_rec
);
    import mhs_pkg::*;

    localparam int     BUCKETS     = (HASH_BUCKETS > 0) ? HASH_BUCKETS : 1;
    localparam int     FOLD_W      = 20;
    localparam int     RECIP_SHIFT = 30;
    localparam int     RECIP_W     = RECIP_SHIFT + 1;
    localparam int     PROD_W      = FOLD_W + RECIP_W;
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + BUCKETS - 1) / BUCKETS;

    localparam logic [FOLD_W-1:0]  W1      = FOLD_W'(256 % BUCKETS);
    localparam logic [FOLD_W-1:0]  W2      = FOLD_W'(65536 % BUCKETS);
    localparam logic [FOLD_W-1:0]  W3      = FOLD_W'(16777216 % BUCKETS);
    localparam logic [FOLD_W-1:0]  DIV_B   = FOLD_W'(BUCKETS);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    logic              st1_valid_reg, st2_valid_reg;
    rec_t              st1_rec_reg, st2_rec_reg;
    logic [FOLD_W-1:0] st1_fold_reg, st1_fold_next;
    logic [FOLD_W-1:0] st2_fold_reg;
    logic [FOLD_W-1:0] st2_quot_reg, st2_quot_next;
    logic [PROD_W-1:0] product;
    logic [FOLD_W-1:0] remainder;

    // Each hash byte is weighted by its place value modulo the bucket count,
    // which keeps the sum small enough for an exact reciprocal divide.
    assign st1_fold_next = FOLD_W'(in_rec.hash[7:0])
                         + FOLD_W'(in_rec.hash[15:8]) * W1
                         + FOLD_W'(in_rec.hash[23:16]) * W2
                         + FOLD_W'(in_rec.hash[31:24]) * W3;

    assign product       = PROD_W'(st1_fold_reg) * PROD_W'(RECIP_C);
    assign st2_quot_next = product[PROD_W-2:RECIP_SHIFT];
    assign remainder     = st2_fold_reg - FOLD_W'(st2_quot_reg * DIV_B);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end
        else begin
            st1_valid_reg <= in_valid;
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_rec_reg  <= in_rec;
        st1_fold_reg <= st1_fold_next;
        st2_rec_reg  <= st1_rec_reg;
        st2_fold_reg <= st1_fold_reg;
        st2_quot_reg <= st2_quot_next;
    end

    always_comb
    begin
        out_rec      = st2_rec_reg;
        out_rec.hash = 32'(remainder);
    end

    assign out_valid = st2_valid_reg;

endmodule

`default_nettype wire

### hw/rtl/mail_header_splitter.sv
// Mail header splitter top level: parser, bucket pipelines and record queue.
//
// Message bytes enter on the byte channel (data_byte, final_byte) under
// byte_valid/byte_stall; a beat is taken when byte_valid is high and
// byte_stall is low. Header and end-of-headers records leave on the record
// channel under record_valid/record_stall, one record per beat.
// One byte is taken every cycle while byte_valid is high and byte_stall is low.
// A byte may cause up to two records; the first record of a byte reaches the
// record outputs through the parser register, two stages that reduce the name
// hash to a bucket, then the queue write; the second is queued with it.
// Records wait in an eight-entry queue. The byte channel raises byte_stall
// while more than six records are taken but not yet delivered, so a
// receiver that stalls the record channel throttles the byte side once the
// queue fills; nothing is dropped. Records leave at one per cycle while
// record_stall is low, which keeps up with any byte stream at full rate.
// Reset empties the queue and puts the parser at the start of a message.
// The final byte of a message also returns the parser to that state.
`default_nettype none

module mail_header_splitter #(
    parameter int MAX_MESSAGE_BYTES = 65536,
    parameter int HASH_BUCKETS      = 63
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             record_valid,
    input  wire logic        record_stall,
    output logic             record_kind,
    output logic [15:0]      offset,
    output logic [15:0]      total_length,
    output logic [15:0]      name_length,
    output logic [15:0]      value_length,
    output logic [15:0]      unfolded_length,
    output logic             no_colon,
    output logic             bad_name_chars,
    output logic [5:0]       name_bucket,
    output logic             body_present,
    output logic             last
);
    import mhs_pkg::*;

    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam logic [QCNT_W-1:0] STALL_LEVEL = QCNT_W'(QDEPTH - 2);

    logic              take;
    logic [1:0]        lane_valid;
    rec_t              lane_rec [2];
    logic [1:0]        rec_count;
    logic [1:0]        push_valid;
    rec_t              push_rec [2];
    logic              pop;
    rec_t              head;

    rec_t              queue_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic [QCNT_W-1:0] owed_reg, owed_next;
    logic [QCNT_W-1:0] push_count;

    assign take = byte_valid && !byte_stall;
    assign pop  = record_valid && !record_stall;

    mhs_parser #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .lane_valid (lane_valid),
        .lane_rec   (lane_rec),
        .rec_count  (rec_count)
    );

    mhs_bucket_pipe #(
        .HASH_BUCKETS(HASH_BUCKETS)
    ) u_pipe0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lane_valid[0]),
        .in_rec    (lane_rec[0]),
        .out_valid (push_valid[0]),
        .out_rec   (push_rec[0])
    );

    mhs_bucket_pipe #(
        .HASH_BUCKETS(HASH_BUCKETS)
    ) u_pipe1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lane_valid[1]),
        .in_rec    (lane_rec[1]),
        .out_valid (push_valid[1]),
        .out_rec   (push_rec[1])
    );

    // The second lane only carries a record when the first one does too.
    assign push_count  = QCNT_W'(push_valid[0]) + QCNT_W'(push_valid[1]);
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign fill_next   = fill_reg + push_count - QCNT_W'(pop);
    // Counts every record from parser to output so the queue can never overflow.
    assign owed_next   = owed_reg + QCNT_W'(rec_count) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            owed_reg   <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            owed_reg   <= owed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid[0]) begin
            queue_mem[wr_ptr_reg] <= push_rec[0];
        end
        if (push_valid[1]) begin
            queue_mem[wr_ptr_reg + 1'b1] <= push_rec[1];
        end
    end

    assign byte_stall   = (owed_reg > STALL_LEVEL);
    assign record_valid = (fill_reg != '0);
    assign head         = queue_mem[rd_ptr_reg];

    assign record_kind     = head.record_kind;
    assign offset          = head.offset;
    assign total_length    = head.total_length;
    assign name_length     = head.name_length;
    assign value_length    = head.value_length;
    assign unfolded_length = head.unfolded_length;
    assign no_colon        = head.no_colon;
    assign bad_name_chars  = head.bad_name_chars;
    assign name_bucket     = head.hash[5:0];
    assign body_present    = head.body_present;
    assign last            = head.last;

endmodule

`default_nettype wire
